// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SVA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define SVA_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define SVA_ASSERT(label, clk, rst_n, prop)
`define SVA_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== rtl/sha256_pkg.sv =====
// Types and constants of the SHA-256 stream hasher.
package sha256_pkg;

  typedef enum logic [1:0] {
    BSEL_DATA = 2'd0,
    BSEL_PAD  = 2'd1,
    BSEL_ZERO = 2'd2,
    BSEL_LEN  = 2'd3
  } byte_sel_t;

  typedef struct packed {
    logic      push;
    byte_sel_t sel;
    logic      load_vars;
    logic      round_en;
    logic      add;
    logic      emit_step;
    logic      restart;
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       last_round;
    logic       last_idx;
  } sha_stat_t;

  localparam logic [31:0] IV [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LAST_FILL = 6'd63;
  localparam logic [5:0] LEN_FILL  = 6'd56;

endpackage

// ===== rtl/sha256_datapath.sv =====
// Datapath: block shift window, message schedule, round unit and chaining words.
module sha256_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha256_pkg::sha_cmd_t cmd,
  input  logic [7:0]           data_byte,
  output sha256_pkg::sha_stat_t stat,
  output logic [31:0]          digest_word,
  output logic [2:0]           word_index
);
  import sha256_pkg::*;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] win_r [0:15];
  logic [31:0] h_r   [0:7];
  logic [31:0] v_r   [0:7];
  logic [5:0]  fill_r;
  logic [5:0]  rnd_r;
  logic [63:0] bits_r;
  logic [2:0]  idx_r;

  logic [7:0]  push_byte;
  logic [5:0]  len_shift;
  logic [31:0] w_new, t1, t2, s0, s1, bs0, bs1, ch, maj;

  assign len_shift = {3'd7 - fill_r[2:0], 3'b000};

  always_comb begin
    unique case (cmd.sel)
      BSEL_DATA: push_byte = data_byte;
      BSEL_PAD:  push_byte = PAD_BYTE;
      BSEL_ZERO: push_byte = 8'h00;
      BSEL_LEN:  push_byte = 8'(bits_r >> len_shift);
      default:   push_byte = 8'h00;
    endcase
  end

  always_comb begin
    s0    = rotr(win_r[14], 7) ^ rotr(win_r[14], 18) ^ (win_r[14] >> 3);
    s1    = rotr(win_r[1], 17) ^ rotr(win_r[1], 19) ^ (win_r[1] >> 10);
    w_new = win_r[15] + s0 + win_r[6] + s1;
    bs1   = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1    = v_r[7] + bs1 + ch + ROUND_K[rnd_r] + win_r[15];
    bs0   = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2    = bs0 + maj;
  end

  // The window shifts bytes in during filling and whole words during rounds;
  // the oldest word always sits at the top.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      win_r[0] <= {win_r[0][23:0], push_byte};
      for (int k = 1; k < 16; k++) win_r[k] <= {win_r[k][23:0], win_r[k-1][31:24]};
    end else if (cmd.round_en) begin
      win_r[0] <= w_new;
      for (int k = 1; k < 16; k++) win_r[k] <= win_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_vars) begin
      for (int k = 0; k < 8; k++) v_r[k] <= h_r[k];
    end else if (cmd.round_en) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      for (int k = 0; k < 8; k++) h_r[k] <= IV[k];
      fill_r <= '0;
      bits_r <= '0;
      rnd_r  <= '0;
      idx_r  <= '0;
    end else begin
      if (cmd.add) begin
        for (int k = 0; k < 8; k++) h_r[k] <= h_r[k] + v_r[k];
      end
      if (cmd.push) fill_r <= fill_r + 6'd1;
      if (cmd.push && cmd.sel == BSEL_DATA) bits_r <= bits_r + 64'd8;
      if (cmd.load_vars) rnd_r <= '0;
      else if (cmd.round_en) rnd_r <= rnd_r + 6'd1;
      if (cmd.emit_step) idx_r <= idx_r + 3'd1;
    end
  end

  assign stat.fill       = fill_r;
  assign stat.last_round = (rnd_r == 6'd63);
  assign stat.last_idx   = (idx_r == 3'd7);
  assign digest_word     = h_r[idx_r];
  assign word_index      = idx_r;

endmodule

// ===== rtl/sha256_ctrl.sv =====
// Controller: sequences byte intake, padding, compression and digest output.
`include "assert_macros.svh"
module sha256_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_has_byte,
  input  logic                  in_end_of_message,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  sha256_pkg::sha_stat_t stat,
  output sha256_pkg::sha_cmd_t  cmd
);
  import sha256_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_ADD   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   eom_r, eom_nxt;
  logic   sent_r, sent_nxt;
  logic   ok_r, ok_nxt;
  logic   final_r, final_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

  always_comb begin
    state_nxt = state_r;
    eom_nxt   = eom_r;
    sent_nxt  = sent_r;
    ok_nxt    = ok_r;
    final_nxt = final_r;
    cmd       = '0;
    cmd.sel   = BSEL_DATA;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_has_byte) begin
            cmd.push = 1'b1;
            if (stat.fill == LAST_FILL) begin
              cmd.load_vars = 1'b1;
              eom_nxt       = in_end_of_message;
              state_nxt     = ST_ROUND;
            end else if (in_end_of_message) begin
              state_nxt = ST_PAD;
            end
          end else if (in_end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.push = 1'b1;
        if (!sent_r) begin
          cmd.sel  = BSEL_PAD;
          sent_nxt = 1'b1;
          ok_nxt   = (stat.fill < LEN_FILL);
        end else if (ok_r && stat.fill >= LEN_FILL) begin
          cmd.sel = BSEL_LEN;
        end else begin
          cmd.sel = BSEL_ZERO;
        end
        if (stat.fill == LAST_FILL) begin
          cmd.load_vars = 1'b1;
          final_nxt     = sent_r && ok_r;
          state_nxt     = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        if (stat.last_round) state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        if (final_r) begin
          state_nxt = ST_EMIT;
        end else if (sent_r) begin
          // The marker landed too late for the length: a second block follows.
          ok_nxt    = 1'b1;
          state_nxt = ST_PAD;
        end else if (eom_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          cmd.emit_step = 1'b1;
          if (stat.last_idx) begin
            cmd.restart = 1'b1;
            eom_nxt     = 1'b0;
            sent_nxt    = 1'b0;
            ok_nxt      = 1'b0;
            final_nxt   = 1'b0;
            state_nxt   = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      eom_r   <= 1'b0;
      sent_r  <= 1'b0;
      ok_r    <= 1'b0;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      eom_r   <= eom_nxt;
      sent_r  <= sent_nxt;
      ok_r    <= ok_nxt;
      final_r <= final_nxt;
    end
  end

  `SVA_NEVER(a_ready_vs_valid, clk, rst_n, in_ready && out_valid)
  `SVA_ASSERT(a_round_to_add, clk, rst_n,
    (state_r == ST_ROUND && stat.last_round) |=> (state_r == ST_ADD))
  `SVA_ASSERT(a_emit_done, clk, rst_n,
    (out_valid && out_ready && stat.last_idx) |=> (state_r == ST_IDLE && stat.fill == 6'd0))

endmodule

// ===== rtl/sha256_stream_hasher_top.sv =====
// Top level of the SHA-256 stream hasher.
// Takes at most one message byte per item and returns the digest as eight 32-bit
// words, word 0 first. A byte item that neither completes a block nor ends the
// message leaves the hasher ready for the next item. The item that completes a 64-byte
// block makes it busy for the 64 rounds of the single round unit and the fold of the
// result into the chaining words. An end-of-message item starts padding, pushed one
// byte per cycle into the block window, then one compression. When fewer than nine
// bytes were free, a second padded block and a second compression follow. After that
// come the eight digest words, one per accepted item.
// No further input item is accepted until the last digest word has been taken.
module sha256_stream_hasher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_has_byte,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha256_pkg::*;

  sha_cmd_t  cmd;
  sha_stat_t stat;

  sha256_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .stat              (stat),
    .cmd               (cmd)
  );

  sha256_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_data_byte),
    .stat        (stat),
    .digest_word (out_digest_word),
    .word_index  (out_word_index)
  );

  assign out_last_word = stat.last_idx;

endmodule

// ===== verif/sha256_digest_checker.sv =====
// Checker for the SHA-256 stream hasher: predicts digests and compares result items.
module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_has_byte,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_message,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_word,
  output int          fail_count,
  output int          pending_words,
  output int          digest_count
);
  import sha256_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic [31:0]  chain [0:7];
  logic [7:0]   block [0:63];
  logic [6:0]   fill;
  logic [63:0]  msg_bits;
  digest_word_t digest_q [$];

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [0:63];
    logic [31:0] v [0:7];
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {block[4*t], block[4*t+1], block[4*t+2], block[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = w[t-16] + w[t-7]
           + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
           + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endtask

  task automatic absorb_item(logic has, logic [7:0] data, logic eom);
    logic [63:0] total;
    logic [5:0]  pos;
    if (has) begin
      block[fill[5:0]] = data;
      fill = fill + 7'd1;
      if (fill == 7'd64) begin
        compress();
        msg_bits = msg_bits + 64'd512;
        fill = 7'd0;
      end
    end
    if (eom) begin
      pos = fill[5:0];
      total = msg_bits + 64'(pos) * 64'd8;
      block[pos] = PAD_BYTE;
      for (int i = int'(pos) + 1; i < 64; i++) block[i] = 8'h00;
      if (pos >= 6'd56) begin
        compress();
        for (int i = 0; i < 56; i++) block[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) block[56+i] = total[63 - 8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) digest_q.push_back('{chain[i], 3'(i), i == 7});
      for (int i = 0; i < 8; i++) chain[i] = IV[i];
      fill = 7'd0;
      msg_bits = 64'd0;
    end
  endtask

  always @(posedge clk) begin
    digest_word_t exp_w;
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) chain[i] = IV[i];
      fill = 7'd0;
      msg_bits = 64'd0;
      digest_q.delete();
      fail_count <= 0;
      digest_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected result item: got word %h index %0d last %b",
                   $time, out_digest_word, out_word_index, out_last_word);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = digest_q.pop_front();
          if (exp_w != {out_digest_word, out_word_index, out_last_word}) begin
            $display("%0t: digest mismatch: expected %h/%0d/%b, got %h/%0d/%b", $time,
                     exp_w.word, exp_w.idx, exp_w.last,
                     out_digest_word, out_word_index, out_last_word);
            fail_count <= fail_count + 1;
          end
          if (exp_w.last) digest_count <= digest_count + 1;
        end
      end
      if (in_valid && in_ready)
        absorb_item(in_has_byte, in_data_byte, in_end_of_message);
    end
    pending_words <= digest_q.size();
  end
endmodule

// ===== verif/tb_sha256_stream_hasher_top.sv =====
// Testbench top for the SHA-256 stream hasher: stimulus, back-pressure and verdict.
module tb_sha256_stream_hasher_top;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_has_byte = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;
  int          fail_count, pending_words, digest_count;
  int          items_sent = 0;
  int          cycles = 0;
  bit          calm = 1'b0;
  bit          hold_off = 1'b0;

  localparam int TOTAL_ITEMS = 420;
  localparam int CYCLE_LIMIT = 400000;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sha256_stream_hasher_top u_top (.*);

  sha256_digest_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("sha256_stream_hasher_top: mismatch");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off, none near the end.
  initial begin : receiver
    int n;
    @(posedge clk iff rst_n);
    while (1) begin
      if (hold_off) begin
        out_ready <= 1'b0;
        for (n = 0; n < 400; n++) @(posedge clk);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(logic has, logic [7:0] data, logic eom);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_has_byte <= has;
    in_data_byte <= data;
    in_end_of_message <= eom;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_message(int len, bit bare_end);
    for (int i = 0; i < len; i++)
      send_item(1'b1, 8'($urandom), !bare_end && i == len - 1);
    if (bare_end || len == 0) send_item(1'b0, 8'($urandom), 1'b1);
  endtask

  initial begin
    int len;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: empty message, field extremes, idle and ignored-byte items.
    send_item(1'b0, 8'hff, 1'b1);
    send_item(1'b1, 8'h00, 1'b1);
    send_item(1'b1, 8'hff, 1'b1);
    send_item(1'b0, 8'h5a, 1'b0);
    send_item(1'b1, 8'h61, 1'b0);
    send_item(1'b0, 8'ha5, 1'b0);
    send_item(1'b1, 8'h62, 1'b0);
    send_item(1'b1, 8'h63, 1'b1);
    send_item(1'b0, 8'h00, 1'b0);
    send_item(1'b1, 8'h80, 1'b0);
    send_item(1'b0, 8'h7f, 1'b1);
    // Lengths around the padding boundaries and the block boundary.
    send_message(55, 1'b0);
    send_message(56, 1'b1);
    send_message(63, 1'b0);
    send_message(64, 1'b1);
    // The receiver holds off while the sender keeps offering items.
    hold_off = 1'b1;
    send_message(20, 1'b0);
    send_message(20, 1'b0);
    send_message(3, 1'b0);
    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent > TOTAL_ITEMS - 60) calm = 1'b1;
      case ($urandom_range(0, 5))
        0: len = $urandom_range(0, 3);
        1: len = $urandom_range(54, 66);
        2: len = $urandom_range(118, 130);
        3: begin
          send_item(1'b0, 8'($urandom), 1'b0);
          continue;
        end
        default: len = $urandom_range(1, 40);
      endcase
      // Keep the total close to the planned item count.
      if (len > TOTAL_ITEMS - items_sent) len = TOTAL_ITEMS - items_sent;
      send_message(len, 1'($urandom_range(0, 1)));
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0 || out_valid) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d items, checked %0d digests across empty, boundary and multi-block",
             items_sent, digest_count);
    $display("messages, with idle items, bare end markers and a long output stall.");
    if (fail_count == 0) begin
      $display("sha256_stream_hasher_top: match");
    end else begin
      $display("sha256_stream_hasher_top: mismatch");
    end
    $finish;
  end
endmodule
